@@ rtl/lbps_pkg.sv @@
// Shared types, request codes and pattern tables for the LED blink pattern sequencer.
`default_nettype none

package lbps_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_POLL  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // Pattern codes carried in pattern_code.
  localparam logic [2:0] PAT_FULL  = 3'd0;
  localparam logic [2:0] PAT_F20   = 3'd1;
  localparam logic [2:0] PAT_F50   = 3'd2;
  localparam logic [2:0] PAT_F100  = 3'd3;
  localparam logic [2:0] PAT_F200  = 3'd4;
  localparam logic [2:0] PAT_F300  = 3'd5;
  localparam logic [2:0] PAT_FLASH = 3'd6;

  localparam int PATTERN_COUNT = 7;   // patterns in the table
  localparam int PASS_WRAP     = 100; // pass counter wraps to 0 above this

  localparam int CODE_W  = 3;
  localparam int LIMIT_W = 7;
  localparam int IDX_W   = 3;  // pair index runs 0..4
  localparam int TICK_W  = 10;
  localparam int PASS_W  = 8;

  typedef struct packed {
    logic                 active;
    logic                 pat_valid;
    logic [CODE_W-1:0]    pattern;
    logic [IDX_W-1:0]     pair_index;
    logic [TICK_W-1:0]    tick_count;
    logic [TICK_W-1:0]    hold_ticks;
    logic                 led_level;
    logic [PASS_W-1:0]    pass_count;
    logic [LIMIT_W-1:0]   pass_limit;
  } seq_state_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic                 tick_elapsed;
    logic [CODE_W-1:0]    pattern_code;
    logic [LIMIT_W-1:0]   loop_limit;
  } req_item_t;

  // Number of (level, hold) pairs in each pattern.
  function automatic logic [IDX_W-1:0] pat_len(input logic [CODE_W-1:0] code);
    case (code)
      PAT_FULL:  pat_len = 3'd1;
      PAT_F20:   pat_len = 3'd2;
      PAT_F50:   pat_len = 3'd2;
      PAT_F100:  pat_len = 3'd2;
      PAT_F200:  pat_len = 3'd2;
      PAT_F300:  pat_len = 3'd2;
      PAT_FLASH: pat_len = 3'd4;
      default:   pat_len = 3'd0;
    endcase
  endfunction

  // LED level of a pair; only the flash pattern lights a pair past the first.
  function automatic logic pat_level(input logic [CODE_W-1:0] code,
                                     input logic [1:0] idx);
    case (idx)
      2'd0:    pat_level = 1'b1;
      2'd2:    pat_level = (code == PAT_FLASH);
      default: pat_level = 1'b0;
    endcase
  endfunction

  // Hold time of a pair, in timer ticks.
  function automatic logic [TICK_W-1:0] pat_hold(input logic [CODE_W-1:0] code,
                                                 input logic [1:0] idx);
    logic [TICK_W-1:0] base;
    case (code)
      PAT_FULL: base = 10'd1;
      PAT_F20:  base = 10'd20;
      PAT_F50:  base = 10'd50;
      PAT_F100: base = 10'd100;
      PAT_F200: base = 10'd200;
      PAT_F300: base = 10'd300;
      default:  base = 10'd0;
    endcase
    if (code == PAT_FLASH) begin
      case (idx)
        2'd0:    pat_hold = 10'd100;
        2'd1:    pat_hold = 10'd200;
        2'd2:    pat_hold = 10'd100;
        default: pat_hold = 10'd800;
      endcase
    end else if (idx == 2'd0 || (idx == 2'd1 && code != PAT_FULL)) begin
      pat_hold = base;
    end else begin
      pat_hold = '0;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/lbps_step.sv @@
// Next-state logic of the sequencer for one request item.
`default_nettype none

module lbps_step (
  input  wire lbps_pkg::seq_state_t st,
  input  wire lbps_pkg::req_item_t  req,
  output lbps_pkg::seq_state_t      st_next
);

  logic [lbps_pkg::TICK_W-1:0] tick_sat;
  logic [lbps_pkg::IDX_W-1:0]  len;
  logic                        in_range;
  logic [lbps_pkg::PASS_W-1:0] pass_inc;
  logic [lbps_pkg::PASS_W-1:0] pass_wrap;

  assign tick_sat  = (req.tick_elapsed && st.tick_count != '1) ?
                     st.tick_count + lbps_pkg::TICK_W'(1) : st.tick_count;
  assign len       = lbps_pkg::pat_len(st.pattern);
  assign in_range  = st.pair_index < len;
  assign pass_inc  = st.pass_count + lbps_pkg::PASS_W'(1);
  assign pass_wrap = (pass_inc > lbps_pkg::PASS_W'(lbps_pkg::PASS_WRAP)) ? '0 : pass_inc;

  always_comb begin
    st_next = st;
    case (req.req_type)
      lbps_pkg::REQ_START: begin
        if (req.pattern_code < lbps_pkg::CODE_W'(lbps_pkg::PATTERN_COUNT)) begin
          st_next.pass_limit = req.loop_limit;
          if (!(st.pat_valid && st.pattern == req.pattern_code)) begin
            st_next.active     = 1'b1;
            st_next.pat_valid  = 1'b1;
            st_next.pattern    = req.pattern_code;
            st_next.pass_count = '1;
            st_next.tick_count = '0;
            st_next.pair_index = '0;
            st_next.led_level  = lbps_pkg::pat_level(req.pattern_code, 2'd0);
            st_next.hold_ticks = lbps_pkg::pat_hold(req.pattern_code, 2'd0);
          end
        end
      end
      lbps_pkg::REQ_STOP: begin
        st_next.active     = 1'b0;
        st_next.pat_valid  = 1'b0;
        st_next.pass_count = '1;
        st_next.led_level  = 1'b0;
      end
      lbps_pkg::REQ_POLL: begin
        if (st.active) begin
          st_next.tick_count = tick_sat;
          if (tick_sat >= st.hold_ticks) begin
            st_next.tick_count = '0;
            if (in_range) begin
              // fetch the pair at the index, then step on
              st_next.led_level  = lbps_pkg::pat_level(st.pattern, st.pair_index[1:0]);
              st_next.hold_ticks = lbps_pkg::pat_hold(st.pattern, st.pair_index[1:0]);
              st_next.pair_index = st.pair_index + lbps_pkg::IDX_W'(1);
            end else begin
              // one past the end: off, zero hold, pass closes
              st_next.led_level  = 1'b0;
              st_next.hold_ticks = '0;
              st_next.pair_index = '0;
              st_next.pass_count = pass_wrap;
              if (st.pass_limit != '0 && pass_wrap >= {1'b0, st.pass_limit}) begin
                st_next.active     = 1'b0;
                st_next.pat_valid  = 1'b0;
                st_next.pass_count = '1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/led_blink_pattern_sequencer_unit.sv @@
// Top level of the LED blink pattern sequencer: input register, step logic, result register.
`default_nettype none

// The block plays one of seven fixed LED patterns (full, 20/50/100/200/300-tick
// blinks, flash) and answers every request item with exactly one result item
// giving the LED level and whether a pattern is playing. The request kind
// travels on s_tuser. Poll items advance the pattern clock by one tick when
// tick_elapsed is set; start items select a pattern and a pass limit (0 runs
// until stopped; restarting the running pattern only changes the limit); stop
// items turn the LED off. An accepted item sits in the input register and goes
// through the step logic into the result register once that register is free
// (empty or being taken); a new item is accepted every cycle while results are
// taken, with one state update per item. A stall on the result side holds
// the result register and, after one more item lands in the input register,
// drops s_tready.
module led_blink_pattern_sequencer_unit (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [15:0] s_tdata,   // [0] tick_elapsed, [3:1] pattern_code,
                                // [10:4] loop_limit
  input  wire [1:0]  s_tuser,   // [1:0] req_type
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata    // [0] led_on, [1] running
);

  // input register
  logic                 in_valid;
  lbps_pkg::req_item_t  in_item;

  // sequencer state
  lbps_pkg::seq_state_t st;
  lbps_pkg::seq_state_t st_next;

  logic advance;  // input register item is processed this cycle

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type     <= s_tuser;
      in_item.tick_elapsed <= s_tdata[0];
      in_item.pattern_code <= s_tdata[3:1];
      in_item.loop_limit   <= s_tdata[10:4];
    end
  end

  lbps_step u_step (
    .st      (st),
    .req     (in_item),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.active     <= 1'b0;
      st.pat_valid  <= 1'b0;
      st.pattern    <= '0;
      st.pair_index <= '0;
      st.tick_count <= '0;
      st.hold_ticks <= '0;
      st.led_level  <= 1'b0;
      st.pass_count <= '1;
      st.pass_limit <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'b0, st_next.active, st_next.led_level};
    end
  end

  // LED is only lit while a pattern plays
  a_led_needs_active : assert property (@(posedge clk) disable iff (rst)
    st.led_level |-> st.active)
    else $error("LED lit while sequencer stopped");

  // playing implies a pattern is selected
  a_active_has_pattern : assert property (@(posedge clk) disable iff (rst)
    st.active |-> st.pat_valid)
    else $error("sequencer active without a valid pattern");

  // a stalled result blocks state updates
  a_stall_holds_state : assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |=> $stable(st))
    else $error("state changed while result stalled");

  // the pair index never runs past the end marker
  a_index_bound : assert property (@(posedge clk) disable iff (rst)
    st.active |-> (st.pair_index <= lbps_pkg::pat_len(st.pattern)))
    else $error("pair index past end of pattern");

endmodule

`default_nettype wire
